[src/ssa_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the spring strain accumulator
package ssa_pkg;

   localparam int FIELD_BITS         = 60;
   localparam int LEVERAGE_BITS      = 48;
   localparam int COORD_BITS_DEFAULT = 20;
   localparam int SUM_BITS_DEFAULT   = 48;
   localparam int SQUARE_STEPS       = 6;
   localparam int SQUARE_CNT_BITS    = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_DIFF,
      ST_MULT,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic                       load;
      logic                       square;
      logic [SQUARE_CNT_BITS-1:0] square_index;
      logic                       root_load;
      logic                       root_step;
      logic                       diff;
      logic                       mult;
      logic                       acc;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

[src/ssa_datapath.sv]
`timescale 1ns / 1ps
// datapath: squared distances, two digit-serial square roots and saturating sum
module ssa_datapath #(
   parameter int COORD_BITS = ssa_pkg::COORD_BITS_DEFAULT,
   parameter int SUM_BITS   = ssa_pkg::SUM_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ssa_pkg::cmd_type                   cmd,
   output ssa_pkg::status_type                status,
   input  logic [ssa_pkg::FIELD_BITS-1:0]     atom_a_position,
   input  logic [ssa_pkg::FIELD_BITS-1:0]     atom_b_position,
   input  logic [ssa_pkg::FIELD_BITS-1:0]     atom_a_shift,
   input  logic [ssa_pkg::FIELD_BITS-1:0]     atom_b_shift,
   input  logic                               last_spring,
   output logic [ssa_pkg::LEVERAGE_BITS-1:0]  leverage,
   output logic                               saturated
);

   localparam int PAD_BITS  = 3 * COORD_BITS + ssa_pkg::FIELD_BITS;
   localparam int DIFF_BITS = COORD_BITS + 2;
   localparam int MAG_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * COORD_BITS + 4;
   localparam int RW        = SQ_BITS / 2;
   localparam int REM_BITS  = RW + 1;
   localparam int D2_BITS   = 2 * RW;
   localparam int ACC_BITS  = ((SUM_BITS > D2_BITS) ? SUM_BITS : D2_BITS) + 1;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   logic [ssa_pkg::FIELD_BITS-1:0] pa_word_ff, pb_word_ff, sa_word_ff, sb_word_ff;
   logic                           last_ff;
   logic [SQ_BITS-1:0]             rest_sq_ff, rest_sq_in;
   logic [SQ_BITS-1:0]             disp_sq_ff, disp_sq_in;
   logic [SQ_BITS-1:0]             rad_r_ff, rad_d_ff;
   logic [REM_BITS-1:0]            rem_r_ff, rem_d_ff, rem_r_in, rem_d_in;
   logic [RW-1:0]                  root_r_ff, root_d_ff, root_r_in, root_d_in;
   logic [RW-1:0]                  dr_ff;
   logic [D2_BITS-1:0]             d2_ff;
   logic [SUM_BITS-1:0]            sum_ff;
   logic                           clip_ff;
   logic [ssa_pkg::LEVERAGE_BITS-1:0] leverage_ff;
   logic                           saturated_ff;

   logic signed [COORD_BITS-1:0]   pa [3];
   logic signed [COORD_BITS-1:0]   pb [3];
   logic signed [COORD_BITS-1:0]   sa [3];
   logic signed [COORD_BITS-1:0]   sb [3];
   logic [PAD_BITS-1:0]            pa_pad, pb_pad, sa_pad, sb_pad;
   logic [1:0]                     k_sel;
   logic signed [DIFF_BITS-1:0]    diff_sel;
   logic [MAG_BITS-1:0]            mag_sel;
   logic [SQ_BITS-1:0]             square;
   logic [ACC_BITS-1:0]            sum_wide;
   logic                           over;
   logic [SUM_BITS-1:0]            sum_next;

   // coordinate unpacking, bits above the field read as zero
   always_comb begin
      pa_pad = PAD_BITS'(pa_word_ff);
      pb_pad = PAD_BITS'(pb_word_ff);
      sa_pad = PAD_BITS'(sa_word_ff);
      sb_pad = PAD_BITS'(sb_word_ff);
      for (int k = 0; k < 3; k++) begin
         pa[k] = pa_pad[k * COORD_BITS +: COORD_BITS];
         pb[k] = pb_pad[k * COORD_BITS +: COORD_BITS];
         sa[k] = sa_pad[k * COORD_BITS +: COORD_BITS];
         sb[k] = sb_pad[k * COORD_BITS +: COORD_BITS];
      end
   end

   // one shared squarer, rest and displaced terms on alternate steps
   always_comb begin
      k_sel = cmd.square_index[2:1];
      unique case (k_sel)
         2'd0:    diff_sel = cmd.square_index[0]
                     ? (DIFF_BITS'(pa[0]) + DIFF_BITS'(sa[0])) - (DIFF_BITS'(pb[0]) + DIFF_BITS'(sb[0]))
                     : DIFF_BITS'(pa[0]) - DIFF_BITS'(pb[0]);
         2'd1:    diff_sel = cmd.square_index[0]
                     ? (DIFF_BITS'(pa[1]) + DIFF_BITS'(sa[1])) - (DIFF_BITS'(pb[1]) + DIFF_BITS'(sb[1]))
                     : DIFF_BITS'(pa[1]) - DIFF_BITS'(pb[1]);
         default: diff_sel = cmd.square_index[0]
                     ? (DIFF_BITS'(pa[2]) + DIFF_BITS'(sa[2])) - (DIFF_BITS'(pb[2]) + DIFF_BITS'(sb[2]))
                     : DIFF_BITS'(pa[2]) - DIFF_BITS'(pb[2]);
      endcase
      mag_sel = diff_sel[DIFF_BITS-1] ? MAG_BITS'(-diff_sel) : MAG_BITS'(diff_sel);
      square  = SQ_BITS'(mag_sel) * SQ_BITS'(mag_sel);
      rest_sq_in = rest_sq_ff;
      disp_sq_in = disp_sq_ff;
      if (cmd.square_index[0]) begin
         disp_sq_in = disp_sq_ff + square;
      end else begin
         rest_sq_in = rest_sq_ff + square;
      end
   end

   // restoring square root, one result bit per step
   always_comb begin
      logic [REM_BITS+1:0] part_r, part_d, trial_r, trial_d;
      part_r  = {rem_r_ff, rad_r_ff[SQ_BITS-1 -: 2]};
      part_d  = {rem_d_ff, rad_d_ff[SQ_BITS-1 -: 2]};
      trial_r = (REM_BITS + 2)'({root_r_ff, 2'b01});
      trial_d = (REM_BITS + 2)'({root_d_ff, 2'b01});
      if (part_r >= trial_r) begin
         rem_r_in  = REM_BITS'(part_r - trial_r);
         root_r_in = {root_r_ff[RW-2:0], 1'b1};
      end else begin
         rem_r_in  = REM_BITS'(part_r);
         root_r_in = {root_r_ff[RW-2:0], 1'b0};
      end
      if (part_d >= trial_d) begin
         rem_d_in  = REM_BITS'(part_d - trial_d);
         root_d_in = {root_d_ff[RW-2:0], 1'b1};
      end else begin
         rem_d_in  = REM_BITS'(part_d);
         root_d_in = {root_d_ff[RW-2:0], 1'b0};
      end
   end

   // saturating accumulation
   always_comb begin
      sum_wide = ACC_BITS'(sum_ff) + ACC_BITS'(d2_ff);
      over     = sum_wide > ACC_BITS'(SUM_MAX);
      sum_next = over ? SUM_MAX : sum_wide[SUM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pa_word_ff <= atom_a_position;
         pb_word_ff <= atom_b_position;
         sa_word_ff <= atom_a_shift;
         sb_word_ff <= atom_b_shift;
         last_ff    <= last_spring;
         rest_sq_ff <= '0;
         disp_sq_ff <= '0;
      end
      if (cmd.square) begin
         rest_sq_ff <= rest_sq_in;
         disp_sq_ff <= disp_sq_in;
      end
      if (cmd.root_load) begin
         rad_r_ff  <= rest_sq_ff;
         rad_d_ff  <= disp_sq_ff;
         rem_r_ff  <= '0;
         rem_d_ff  <= '0;
         root_r_ff <= '0;
         root_d_ff <= '0;
      end
      if (cmd.root_step) begin
         rad_r_ff  <= rad_r_ff << 2;
         rad_d_ff  <= rad_d_ff << 2;
         rem_r_ff  <= rem_r_in;
         rem_d_ff  <= rem_d_in;
         root_r_ff <= root_r_in;
         root_d_ff <= root_d_in;
      end
      if (cmd.diff) begin
         dr_ff <= (root_d_ff >= root_r_ff) ? root_d_ff - root_r_ff : root_r_ff - root_d_ff;
      end
      if (cmd.mult) begin
         d2_ff <= D2_BITS'(dr_ff) * D2_BITS'(dr_ff);
      end
      if (cmd.acc && last_ff) begin
         leverage_ff  <= ssa_pkg::LEVERAGE_BITS'(sum_next);
         saturated_ff <= clip_ff | over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         clip_ff <= 1'b0;
      end else if (cmd.acc) begin
         if (last_ff) begin
            sum_ff  <= '0;
            clip_ff <= 1'b0;
         end else begin
            sum_ff  <= sum_next;
            clip_ff <= clip_ff | over;
         end
      end
   end

   assign status.last = last_ff;
   assign leverage    = leverage_ff;
   assign saturated   = saturated_ff;

endmodule

[src/ssa_controller.sv]
`timescale 1ns / 1ps
// controller: sequences one spring word through the datapath and owns the handshakes
module ssa_controller #(
   parameter int COORD_BITS = ssa_pkg::COORD_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output ssa_pkg::cmd_type    cmd,
   input  ssa_pkg::status_type status
);

   localparam int RW       = COORD_BITS + 2;
   localparam int CNT_BITS = $clog2(RW);

   ssa_pkg::state_type                  state_ff, state_in;
   logic [ssa_pkg::SQUARE_CNT_BITS-1:0] sq_cnt_ff, sq_cnt_in;
   logic [CNT_BITS-1:0]                 root_cnt_ff, root_cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                out_blocked;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssa_pkg::ST_IDLE;
         sq_cnt_ff    <= '0;
         root_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sq_cnt_ff    <= sq_cnt_in;
         root_cnt_ff  <= root_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sq_cnt_in    = sq_cnt_ff;
      root_cnt_in  = root_cnt_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      out_blocked  = rsp_valid_ff & ~rsp_tready;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd.square_index = sq_cnt_ff;
      unique case (state_ff)
         ssa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load  = 1'b1;
               sq_cnt_in = '0;
               state_in  = ssa_pkg::ST_SQUARE;
            end
         end
         ssa_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            if (sq_cnt_ff == ssa_pkg::SQUARE_CNT_BITS'(ssa_pkg::SQUARE_STEPS - 1)) begin
               state_in = ssa_pkg::ST_ROOT_LOAD;
            end else begin
               sq_cnt_in = sq_cnt_ff + 1'b1;
            end
         end
         ssa_pkg::ST_ROOT_LOAD: begin
            cmd.root_load = 1'b1;
            root_cnt_in   = CNT_BITS'(RW - 1);
            state_in      = ssa_pkg::ST_ROOT;
         end
         ssa_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (root_cnt_ff == '0) begin
               state_in = ssa_pkg::ST_DIFF;
            end else begin
               root_cnt_in = root_cnt_ff - 1'b1;
            end
         end
         ssa_pkg::ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ssa_pkg::ST_MULT;
         end
         ssa_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ssa_pkg::ST_ACC;
         end
         ssa_pkg::ST_ACC: begin
            // a final word waits until the output register is free
            if (!(status.last && out_blocked)) begin
               cmd.acc  = 1'b1;
               state_in = ssa_pkg::ST_IDLE;
               if (status.last) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ssa_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[src/spring_strain_accumulator.sv]
`timescale 1ns / 1ps
// top level of the spring strain accumulator
//
// req channel: one word per spring and mode, tdata carries four packed
// position and shift words, tlast marks the final spring and mode word of a site.
// each word gives the squared change between rest and displaced spring
// length, summed into a saturating accumulator.
// rsp channel: one word per site, issued for the word that carried tlast,
// holding the sum and the clip flag; the accumulator then clears.
// a word is accepted only after the previous one has left the datapath:
// the shared squarer, the root load, then the two digit-serial square
// roots that take one result bit per cycle over COORD_BITS + 2 steps,
// then the difference, multiply and accumulate steps.
// the result of a site is registered into the output register in the
// accumulate step of its final word.
// when the receiver stalls, the result holds in the output register and a
// further word is still accepted; only a second final word waits for the
// register to drain.
// reset clears the sum, the clip flag and the output valid.
module spring_strain_accumulator #(
   parameter int COORD_BITS = ssa_pkg::COORD_BITS_DEFAULT,
   parameter int SUM_BITS   = ssa_pkg::SUM_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // atom_a_position, atom_b_position, atom_a_shift, atom_b_shift
   input  logic [239:0]  req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // leverage
   output logic [47:0]   rsp_tdata,
   // saturated
   output logic          rsp_tuser
);

   localparam int FB = ssa_pkg::FIELD_BITS;

   ssa_pkg::cmd_type    cmd;
   ssa_pkg::status_type status;

   ssa_controller #(
      .COORD_BITS (COORD_BITS)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ssa_datapath #(
      .COORD_BITS (COORD_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .atom_a_position (req_tdata[0 * FB +: FB]),
      .atom_b_position (req_tdata[1 * FB +: FB]),
      .atom_a_shift    (req_tdata[2 * FB +: FB]),
      .atom_b_shift    (req_tdata[3 * FB +: FB]),
      .last_spring     (req_tlast),
      .leverage        (rsp_tdata),
      .saturated       (rsp_tuser)
   );

endmodule

[src/ssa_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the spring strain accumulator, bound to the top level
module ssa_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [47:0]  rsp_tdata,
   input logic         rsp_tuser
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one word at a time through the datapath
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result appeared straight after acceptance");

endmodule

bind spring_strain_accumulator ssa_checker u_ssa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the spring strain accumulator: directed table, then random sites
module tb_top;

   localparam int          CW     = ssa_pkg::COORD_BITS_DEFAULT;
   localparam logic [19:0] C_MAX  = 20'h7FFFF;
   localparam logic [19:0] C_MIN  = 20'h80000;
   localparam logic [19:0] C_ONES = 20'hFFFFF;
   localparam logic [19:0] C_ZERO = 20'h00000;
   localparam logic [63:0] SUM_FULL = 64'h0000_FFFF_FFFF_FFFF;
   localparam int          RANDOM_WORDS = 450;

   typedef struct {
      logic [59:0] a_pos;
      logic [59:0] b_pos;
      logic [59:0] a_shift;
      logic [59:0] b_shift;
      logic        last;
   } spring_word_type;

   typedef struct {
      logic [47:0] leverage;
      logic        saturated;
   } site_sum_type;

   typedef struct {
      spring_word_type word;
      bit              typed;
      logic [47:0]     leverage;
      logic            saturated;
   } stim_row_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // atom_a_position, atom_b_position, atom_a_shift, atom_b_shift
   logic [239:0] req_tdata  = '0;
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // leverage
   logic [47:0]  rsp_tdata;
   // saturated
   logic         rsp_tuser;

   site_sum_type site_sums_due[$];
   site_sum_type head_sum;
   stim_row_type dir_rows[$];
   logic [63:0]  sum_track  = '0;
   logic         clip_track = 1'b0;
   bit           calm       = 1'b0;
   int           errors     = 0;
   int           words_sent = 0;
   int           sites_checked = 0;
   int           sites_clipped = 0;

   spring_strain_accumulator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic logic [59:0] xyz(logic [19:0] x, logic [19:0] y, logic [19:0] z);
      return {z, y, x};
   endfunction

   function automatic spring_word_type make_word(logic [59:0] a_pos, logic [59:0] b_pos,
                                                 logic [59:0] a_shift, logic [59:0] b_shift,
                                                 logic last);
      spring_word_type w;
      w.a_pos   = a_pos;
      w.b_pos   = b_pos;
      w.a_shift = a_shift;
      w.b_shift = b_shift;
      w.last    = last;
      return w;
   endfunction

   function automatic longint coord_at(logic [59:0] packed_xyz, int k);
      logic signed [CW-1:0] c;
      c = packed_xyz[k*CW +: CW];
      return c;
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // squared change between rest and displaced spring length
   function automatic logic [63:0] spring_strain_sq(spring_word_type w);
      longint      pa, pb, sa, sb, d_rest, d_disp;
      longint      rest_sq, disp_sq;
      logic [63:0] r0, r, dr;
      rest_sq = 0;
      disp_sq = 0;
      for (int k = 0; k < 3; k++) begin
         pa      = coord_at(w.a_pos, k);
         pb      = coord_at(w.b_pos, k);
         sa      = coord_at(w.a_shift, k);
         sb      = coord_at(w.b_shift, k);
         d_rest  = pa - pb;
         d_disp  = (pa + sa) - (pb + sb);
         rest_sq += d_rest * d_rest;
         disp_sq += d_disp * d_disp;
      end
      r0 = floor_root(rest_sq);
      r  = floor_root(disp_sq);
      dr = (r >= r0) ? r - r0 : r0 - r;
      return dr * dr;
   endfunction

   function automatic logic [19:0] rand_coord();
      logic [19:0] c;
      case ($urandom_range(0, 4))
         0, 1: c = 20'($urandom);
         2: c = 20'($urandom_range(0, 1023) - 512);
         3: begin
            case ($urandom_range(0, 4))
               0: c = C_MAX;
               1: c = C_MIN;
               2: c = C_ONES;
               3: c = 20'd1;
               default: c = C_ZERO;
            endcase
         end
         default: c = 20'($urandom_range(0, 6) - 3);
      endcase
      return c;
   endfunction

   function automatic logic [59:0] rand_xyz();
      return xyz(rand_coord(), rand_coord(), rand_coord());
   endfunction

   task automatic send_word(spring_word_type w, int gap, bit typed,
                            logic [47:0] typed_lev, logic typed_sat);
      logic [63:0]  strain;
      site_sum_type due;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {w.b_shift, w.a_shift, w.b_pos, w.a_pos};
      req_tlast  <= w.last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      strain = spring_strain_sq(w);
      if (strain > SUM_FULL - sum_track) begin
         sum_track  = SUM_FULL;
         clip_track = 1'b1;
      end else begin
         sum_track = sum_track + strain;
      end
      if (w.last) begin
         due.leverage  = typed ? typed_lev : sum_track[47:0];
         due.saturated = typed ? typed_sat : clip_track;
         site_sums_due.push_back(due);
         sum_track  = '0;
         clip_track = 1'b0;
      end
      @(negedge clock);
   endtask

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (site_sums_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual leverage %h saturated %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            head_sum = site_sums_due.pop_front();
            sites_checked++;
            if (rsp_tuser) sites_clipped++;
            if (rsp_tdata !== head_sum.leverage) begin
               errors++;
               $display("%0t: leverage mismatch, expected %h actual %h",
                        $time, head_sum.leverage, rsp_tdata);
            end
            if (rsp_tuser !== head_sum.saturated) begin
               errors++;
               $display("%0t: saturated mismatch, expected %b actual %b",
                        $time, head_sum.saturated, rsp_tuser);
            end
         end
      end
   end

   // receiver with random stalls
   initial begin : rsp_side
      int hold;
      wait (!reset);
      @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      #(10_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      spring_word_type w;
      logic [59:0]     base;
      int              len;
      int              sat_sites;
      bit              paused;

      sat_sites = 0;
      paused    = 0;

      // directed table
      dir_rows.push_back('{make_word('0, '0, '0, '0, 1'b1), 1'b1, 48'h0, 1'b0});
      dir_rows.push_back('{make_word(xyz(C_MAX, C_MAX, C_MAX), xyz(C_MIN, C_MIN, C_MIN),
                                     '0, '0, 1'b0), 1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word(xyz(C_MAX, C_MAX, C_MAX), xyz(C_MIN, C_MIN, C_MIN),
                                     xyz(C_MAX, C_MAX, C_MAX), xyz(C_MIN, C_MIN, C_MIN),
                                     1'b1), 1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word('0, '0, xyz(C_MAX, C_MAX, C_MAX),
                                     xyz(C_MIN, C_MIN, C_MIN), 1'b1), 1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word(xyz(C_MAX, C_MAX, C_MAX), xyz(C_MIN, C_MIN, C_MIN),
                                     xyz(C_MIN, C_MIN, C_MIN), xyz(C_MAX, C_MAX, C_MAX),
                                     1'b1), 1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word(xyz(20'd100, C_ZERO, C_ZERO), '0,
                                     xyz(20'hFFF9C, C_ZERO, C_ZERO), '0, 1'b1),
                           1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word({60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}}, 1'b1),
                           1'b1, 48'h0, 1'b0});
      dir_rows.push_back('{make_word({15{4'hA}}, {15{4'h5}}, {15{4'h5}}, {15{4'hA}}, 1'b0),
                           1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word({15{4'h5}}, {15{4'hA}}, {15{4'hA}}, {15{4'h5}}, 1'b1),
                           1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word(xyz(C_MIN, C_MAX, C_ZERO), xyz(C_MAX, C_MIN, C_ONES),
                                     xyz(20'd1, C_ONES, C_MAX), xyz(C_MIN, C_ZERO, 20'd1),
                                     1'b0), 1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word(xyz(20'd256, C_ZERO, C_ZERO), '0,
                                     xyz(C_ZERO, 20'd256, C_ZERO), '0, 1'b0),
                           1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word(xyz(C_ONES, 20'd3, C_MIN), xyz(20'd7, C_ONES, C_MAX),
                                     xyz(20'd2, C_MAX, C_ONES), xyz(C_MAX, 20'd5, C_ZERO),
                                     1'b1), 1'b0, 48'h0, 1'b0});
      dir_rows.push_back('{make_word(xyz(20'd300, C_ZERO, C_ZERO), '0, '0, '0, 1'b1),
                           1'b1, 48'h0, 1'b0});

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         send_word(dir_rows[i].word, $urandom_range(0, 15), dir_rows[i].typed,
                   dir_rows[i].leverage, dir_rows[i].saturated);

      // random sites
      while (words_sent < RANDOM_WORDS + dir_rows.size()) begin
         calm = ($urandom_range(0, 7) == 0);
         if ((sat_sites == 0 && words_sent > 100) || (sat_sites == 1 && words_sent > 300)) begin
            // long site of full-scale shifts, driving the sum into its clip
            sat_sites++;
            len = $urandom_range(90, 100);
            for (int n = 0; n < len; n++) begin
               base = rand_xyz();
               if ($urandom_range(0, 9) == 0)
                  w = make_word(rand_xyz(), rand_xyz(), rand_xyz(), rand_xyz(), 1'b0);
               else
                  w = make_word(base, base, xyz(C_MAX, C_MAX, C_MAX),
                                xyz(C_MIN, C_MIN, C_MIN), 1'b0);
               w.last = (n == len - 1);
               send_word(w, calm ? 0 : $urandom_range(0, 15), 1'b0, '0, 1'b0);
            end
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2: len = $urandom_range(7, 20);
               3:       len = 1;
               default: len = $urandom_range(1, 6);
            endcase
            for (int n = 0; n < len; n++) begin
               w = make_word(rand_xyz(), rand_xyz(), rand_xyz(), rand_xyz(), n == len - 1);
               if ($urandom_range(0, 3) == 0) w.b_pos = w.a_pos;
               send_word(w, calm ? 0 : $urandom_range(0, 15), 1'b0, '0, 1'b0);
            end
         end
         if (!paused && words_sent > 200) begin
            // sender holds off until the result queue drains
            paused = 1;
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (site_sums_due.size() != 0) @(negedge clock);
         end
      end

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (site_sums_due.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      $display("%0d spring words sent, %0d site sums checked", words_sent, sites_checked);
      $display("%0d site sums clipped at full scale, %0d errors", sites_clipped, errors);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[spring_strain_accumulator.f]
src/ssa_pkg.sv
src/ssa_datapath.sv
src/ssa_controller.sv
src/spring_strain_accumulator.sv
src/ssa_checker.sv
tb/tb_top.sv
